>>> src/sfrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfrc_pkg
// Shared constants and types for the serial frame receiver checksum core.
// ----------------------------------------------------------------------------
package sfrc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W  = 9;
   localparam int unsigned STAT_W = 3;

   localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h5E;
   localparam logic [POS_W-1:0]  LEN_POS  = 9'd4;
   localparam logic [POS_W-1:0]  HDR_LEN  = 9'd2;

   typedef enum logic [STAT_W-1:0] {
      ST_BUSY     = 3'd0,
      ST_GOOD     = 3'd1,
      ST_BAD_HDR  = 3'd2,
      ST_BAD_SUM  = 3'd3,
      ST_ZERO_LEN = 3'd4
   } status_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             frame_end;
      status_type       status;
   } result_type;

endpackage

`default_nettype wire

>>> src/serial_frame_receiver_checksum_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_receiver_checksum_core
// Tracks framing of received serial bytes and checks each frame's checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per transfer. For every byte one
//   transfer appears on rsp_*: its position in the frame, the byte itself,
//   frame_end on the check byte (or on a zero length byte) and the status
//   (good, bad header, bad checksum, zero length; 0 while in progress).
//   A byte that is taken is registered and shown on rsp_* in the cycle after.
//   Throughput is one byte per cycle while no held result is stalled; the frame state update is a
//   9-bit compare and an 8-bit add ahead of the result register.
//   When rsp_stall is high with a result held, req_stall rises and the
//   held result stays unchanged; a result taken in the same cycle frees the
//   register for the next byte at once.
//   Reset empties the result register and returns the tracker to position 0
//   with an empty checksum and a good header verdict.
// ----------------------------------------------------------------------------
module serial_frame_receiver_checksum_core
   import sfrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [POS_W-1:0]  rsp_position,
   output      logic [BYTE_W-1:0] rsp_data_out,
   output      logic              rsp_frame_end,
   output      logic [STAT_W-1:0] rsp_status
);

   logic              valid_ff;
   logic              accept;
   result_type        result;
   result_type        result_ff;
   logic [BYTE_W-1:0] data_ff;

   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   sfrc_frame_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
         data_ff   <= req_rx_byte;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_position  = result_ff.position;
   assign rsp_data_out  = data_ff;
   assign rsp_frame_end = result_ff.frame_end;
   assign rsp_status    = result_ff.status;

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position) && $stable(rsp_data_out))
      else $error("stalled transfer changed");

   a_fill : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted byte produced no result");

   a_drain : assert property (@(posedge clock) disable iff (reset)
      !req_valid && !req_stall |=> !rsp_valid)
      else $error("result without a byte");

endmodule

`default_nettype wire

>>> src/sfrc_frame_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfrc_frame_tracker
// Frame position, length, running checksum and header verdict. Gives the
// result for the byte presented and updates the frame state on a transfer.
// ----------------------------------------------------------------------------
module sfrc_frame_tracker
   import sfrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] rx_byte,
   output      result_type        result
);

   logic [POS_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] length_ff, length_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic              hdr_good_ff, hdr_good_in;
   logic [POS_W-1:0]  check_pos;
   logic [POS_W-1:0]  count_inc;

   assign check_pos = LEN_POS + {1'b0, length_ff};
   assign count_inc = count_ff + 9'd1;

   always_comb begin
      count_in         = count_ff;
      length_in        = length_ff;
      sum_in           = sum_ff;
      hdr_good_in      = hdr_good_ff;
      result.position  = count_ff;
      result.frame_end = 1'b0;
      result.status    = ST_BUSY;
      if (count_ff < HDR_LEN) begin
         if (rx_byte != HDR_BYTE) begin
            hdr_good_in = 1'b0;
         end
         count_in = count_inc;
      end else if (count_ff < LEN_POS) begin
         count_in = count_inc;
      end else if (count_ff == LEN_POS) begin
         length_in = rx_byte;
         sum_in    = rx_byte;
         if (rx_byte == '0) begin
            result.frame_end = 1'b1;
            result.status    = ST_ZERO_LEN;
            count_in         = '0;
            sum_in           = '0;
            hdr_good_in      = 1'b1;
         end else begin
            count_in = count_inc;
         end
      end else if (count_ff < check_pos) begin
         sum_in   = sum_ff + rx_byte;
         count_in = count_inc;
      end else begin
         result.frame_end = 1'b1;
         if (!hdr_good_ff) begin
            result.status = ST_BAD_HDR;
         end else if (sum_ff != rx_byte) begin
            result.status = ST_BAD_SUM;
         end else begin
            result.status = ST_GOOD;
         end
         count_in    = '0;
         sum_in      = '0;
         hdr_good_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         length_ff   <= '0;
         sum_ff      <= '0;
         hdr_good_ff <= 1'b1;
      end else if (accept) begin
         count_ff    <= count_in;
         length_ff   <= length_in;
         sum_ff      <= sum_in;
         hdr_good_ff <= hdr_good_in;
      end
   end

   a_end_status : assert property (@(posedge clock) disable iff (reset)
      result.frame_end == (result.status != ST_BUSY))
      else $error("frame_end and status disagree");

   a_end_rewinds : assert property (@(posedge clock) disable iff (reset)
      accept && result.frame_end |=> count_ff == '0 && sum_ff == '0 && hdr_good_ff)
      else $error("frame state not cleared after frame end");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff > LEN_POS |-> count_ff <= check_pos)
      else $error("position beyond check byte");

   a_advance : assert property (@(posedge clock) disable iff (reset)
      accept && !result.frame_end |=> count_ff == $past(count_inc))
      else $error("position did not advance");

endmodule

`default_nettype wire

>>> tb/sfrc_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_frame_checker
// Watches both channels of the serial frame receiver checksum core. Every
// byte taken on req_* is run through a local frame tracker, and the
// predicted position, byte, frame end and status are queued. Every result
// taken on rsp_* is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sfrc_frame_checker
   import sfrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [BYTE_W-1:0] req_rx_byte,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [POS_W-1:0]  rsp_position,
   input  wire logic [BYTE_W-1:0] rsp_data_out,
   input  wire logic              rsp_frame_end,
   input  wire logic [STAT_W-1:0] rsp_status,
   output int                     pending_count,
   output int                     mismatch_count
);

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [BYTE_W-1:0] data_out;
      logic              frame_end;
      status_type        status;
   } frame_result_t;

   frame_result_t     expected_results[$];
   logic [POS_W-1:0]  next_pos;
   logic [BYTE_W-1:0] frame_len;
   logic [BYTE_W-1:0] check_sum;
   logic              header_ok;

   initial begin
      pending_count  = 0;
      mismatch_count = 0;
   end

   task automatic report(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic restart_frame();
      next_pos  = '0;
      check_sum = '0;
      header_ok = 1'b1;
   endtask

   task automatic track_byte(input logic [BYTE_W-1:0] b, output frame_result_t r);
      logic [POS_W:0] check_pos;
      r.position  = next_pos;
      r.data_out  = b;
      r.frame_end = 1'b0;
      r.status    = ST_BUSY;
      check_pos   = (POS_W+1)'(LEN_POS) + (POS_W+1)'(frame_len);
      if (next_pos < HDR_LEN) begin
         if (b != HDR_BYTE) header_ok = 1'b0;
         next_pos = next_pos + 1'b1;
      end else if (next_pos < LEN_POS) begin
         next_pos = next_pos + 1'b1;
      end else if (next_pos == LEN_POS) begin
         frame_len = b;
         check_sum = b;
         if (b == '0) begin
            r.frame_end = 1'b1;
            r.status    = ST_ZERO_LEN;
            restart_frame();
         end else begin
            next_pos = next_pos + 1'b1;
         end
      end else if ({1'b0, next_pos} < check_pos) begin
         check_sum = check_sum + b;
         next_pos  = next_pos + 1'b1;
      end else begin
         r.frame_end = 1'b1;
         if (!header_ok) r.status = ST_BAD_HDR;
         else if (check_sum != b) r.status = ST_BAD_SUM;
         else r.status = ST_GOOD;
         restart_frame();
      end
   endtask

   always @(posedge clock) begin
      frame_result_t predicted;
      frame_result_t want;
      if (reset) begin
         expected_results.delete();
         frame_len = '0;
         restart_frame();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report($sformatf("unexpected transfer pos=%0d byte=%02h",
                                rsp_position, rsp_data_out));
            end else begin
               want = expected_results.pop_front();
               if (rsp_position !== want.position)
                  report($sformatf("position %0d, want %0d", rsp_position, want.position));
               if (rsp_data_out !== want.data_out)
                  report($sformatf("data_out %02h, want %02h", rsp_data_out, want.data_out));
               if (rsp_frame_end !== want.frame_end)
                  report($sformatf("frame_end %b, want %b at pos %0d",
                                   rsp_frame_end, want.frame_end, want.position));
               if (rsp_status !== want.status)
                  report($sformatf("status %0d, want %0d at pos %0d",
                                   rsp_status, want.status, want.position));
            end
         end
         if (req_valid && !req_stall) begin
            track_byte(req_rx_byte, predicted);
            expected_results.push_back(predicted);
         end
      end
      pending_count = expected_results.size();
   end

endmodule

>>> tb/serial_frame_receiver_checksum_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_checksum_core_test
// Drives the serial frame receiver checksum core with a short directed set
// of frames, then random frames with occasional noise bytes, under three
// idle patterns and one long receiver hold-off. Results are checked by
// sfrc_frame_checker; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module serial_frame_receiver_checksum_core_test;
   import sfrc_pkg::*;

   localparam int PHASE_BYTES = 350;
   localparam int RANDOM_BYTES = 1000;
   localparam int LONG_HOLD = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int N_DIRECTED = 30;

   // good; bad header and bad sum; bad second header byte; bad sum;
   // zero length behind a bad header
   localparam logic [BYTE_W-1:0] DIRECTED [N_DIRECTED] = '{
      8'h5E, 8'h5E, 8'h00, 8'hFF, 8'h01, 8'h01,
      8'h00, 8'h5E, 8'h01, 8'h02, 8'h01, 8'h07,
      8'h5E, 8'hFF, 8'h01, 8'h02, 8'h02, 8'h80, 8'h82,
      8'h5E, 8'h5E, 8'hAA, 8'h55, 8'h01, 8'h00,
      8'h11, 8'h22, 8'h33, 8'h44, 8'h00
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [POS_W-1:0]  rsp_position;
   logic [BYTE_W-1:0] rsp_data_out;
   logic              rsp_frame_end;
   logic [STAT_W-1:0] rsp_status;

   int pending_count;
   int mismatch_count;
   int phase = 0;
   int bytes_sent = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   int quiet_cycles = 0;
   int req_idle_pct;
   int rsp_idle_pct;

   assign req_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 48 : 0;
   assign rsp_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 37 : 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   serial_frame_receiver_checksum_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_position  (rsp_position),
      .rsp_data_out  (rsp_data_out),
      .rsp_frame_end (rsp_frame_end),
      .rsp_status    (rsp_status)
   );

   sfrc_frame_checker frame_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_position   (rsp_position),
      .rsp_data_out   (rsp_data_out),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_status     (rsp_status),
      .pending_count  (pending_count),
      .mismatch_count (mismatch_count)
   );

   // receiver: random stall, plus one long hold-off when the sender stops idling
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (phase == 2 && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD - 1;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("** serial_frame_receiver_checksum_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      phase <= (bytes_sent / PHASE_BYTES > 2) ? 2 : bytes_sent / PHASE_BYTES;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input int len, input logic hdr_ok, input logic sum_ok);
      logic [BYTE_W-1:0] h0;
      logic [BYTE_W-1:0] h1;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] sum;
      h0 = HDR_BYTE;
      h1 = HDR_BYTE;
      if (!hdr_ok) begin
         b = BYTE_W'($urandom_range(255));
         if (b == HDR_BYTE) b = ~b;
         case ($urandom_range(2))
            0: h0 = b;
            1: h1 = b;
            default: begin
               h0 = b;
               h1 = ~b;
            end
         endcase
      end
      send_byte(h0);
      send_byte(h1);
      send_byte(BYTE_W'($urandom_range(255)));
      send_byte(BYTE_W'($urandom_range(255)));
      send_byte(BYTE_W'(len));
      if (len != 0) begin
         sum = BYTE_W'(len);
         for (int i = 1; i < len; i++) begin
            b = BYTE_W'($urandom_range(255));
            sum = sum + b;
            send_byte(b);
         end
         if (!sum_ok) sum = sum ^ BYTE_W'($urandom_range(255, 1));
         send_byte(sum);
      end
   endtask

   initial begin
      int pick;
      int len;
      int big_frames;
      big_frames = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIRECTED; i++) send_byte(DIRECTED[i]);

      send_frame(255, 1'b1, 1'b1);
      while (bytes_sent < RANDOM_BYTES) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            repeat ($urandom_range(4, 1)) send_byte(BYTE_W'($urandom_range(255)));
         end else begin
            pick = $urandom_range(99);
            if (pick < 5) len = 0;
            else if (pick < 6 && big_frames < 2) begin
               len = $urandom_range(255, 200);
               big_frames++;
            end else len = $urandom_range(12, 1);
            send_frame(len, $urandom_range(99) < 88, $urandom_range(99) < 75);
         end
      end
      req_valid <= 1'b0;

      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** serial_frame_receiver_checksum_core: PASSED **");
      end else begin
         $display("** serial_frame_receiver_checksum_core: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/sfrc_pkg.sv
src/sfrc_frame_tracker.sv
src/serial_frame_receiver_checksum_core.sv
tb/sfrc_frame_checker.sv
tb/serial_frame_receiver_checksum_core_test.sv
